[hw/rtl/nv21x_pkg.sv]
// ----------------------------------------------------------------------------
// nv21x_pkg
// Shared types and constants for the NV21 to XRGB pixel converter: the
// request and response words, register indexes and conversion coefficients.
// ----------------------------------------------------------------------------
package nv21x_pkg;

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 13;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

   localparam logic [CSR_DATA_W-1:0] IMAGE_WIDTH_RST  = 13'd640;
   localparam logic [CSR_DATA_W-1:0] IMAGE_HEIGHT_RST = 13'd480;

   // Conversion coefficients (Q10)
   localparam int COEF_Y  = 1192;
   localparam int COEF_RV = 1634;
   localparam int COEF_GV = 833;
   localparam int COEF_GU = 400;
   localparam int COEF_BU = 2066;

   localparam logic [7:0] LUMA_OFFSET   = 8'd16;
   localparam logic [8:0] CHROMA_OFFSET = 9'd128;
   localparam int         SAT_MAX       = 262143;

   // Datapath widths
   localparam int PROD_W = 21;
   localparam int SUM_W  = 22;

   typedef struct packed {
      logic [7:0] luma;
      logic [7:0] chroma_v;
      logic [7:0] chroma_u;
   } req_word_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       end_of_row;
      logic       end_of_frame;
   } rsp_word_type;

   // Clamp a Q10 sum to 0..SAT_MAX and drop the fraction
   function automatic logic [7:0] sat_shift(input logic signed [SUM_W-1:0] s);
      logic [7:0] r;
      if (s < 0) begin
         r = 8'd0;
      end else if (s > SUM_W'(SAT_MAX)) begin
         r = 8'hFF;
      end else begin
         r = s[17:10];
      end
      return r;
   endfunction

endpackage

[hw/rtl/nv21_to_xrgb_converter_core.sv]
// ----------------------------------------------------------------------------
// nv21_to_xrgb_converter_core
// NV21 (4:2:0 semi-planar, V before U) to RGB pixel converter. Even rows
// write their V,U pairs to a chroma line memory, odd rows read them back.
//
//   port group   dir   handshake          payload
//   req_*        in    req_valid/stall    nv21x_pkg::req_word_type
//   rsp_*        out   rsp_valid/stall    nv21x_pkg::rsp_word_type
//   csr_*        in    csr_wr_en          csr_index, csr_wdata
//
// One pixel per clock sustained while rsp is not stalled; an accepted word
// passes the line memory read, the product stage and the sum and output
// register before it shows on rsp.
// The line memory has one port per cycle; one access per pixel at most.
// Reset clears counters, held chroma and pipeline valids; the line memory
// is not cleared and needs no pass after reset.
// A stalled output fills empty stages first; req_stall rises only when all
// three stages hold a word.
// ----------------------------------------------------------------------------
module nv21_to_xrgb_converter_core #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  nv21x_pkg::req_word_type               req_word,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output nv21x_pkg::rsp_word_type               rsp_word,
   input  logic                                  csr_wr_en,
   input  logic [nv21x_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [nv21x_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import nv21x_pkg::*;

   localparam int CNT_W      = (MAX_WIDTH > 4) ? $clog2(MAX_WIDTH) : 2;
   localparam int LIM_W      = CNT_W + 1;
   localparam int LINE_DEPTH = MAX_WIDTH / 2;
   localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam int EXT_W      = CSR_DATA_W + 1;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [CSR_DATA_W-1:0] image_width_ff;
   logic [CSR_DATA_W-1:0] image_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= IMAGE_WIDTH_RST;
         image_height_ff <= IMAGE_HEIGHT_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  image_width_ff  <= csr_wdata;
            REG_IMAGE_HEIGHT: image_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Effective limits: width even and in 2..MAX_WIDTH, height in 1..MAX_WIDTH
   logic [EXT_W-1:0] width_even;
   logic [EXT_W-1:0] height_ext;
   logic [LIM_W-1:0] eff_width;
   logic [LIM_W-1:0] eff_height;

   always_comb begin
      width_even = {1'b0, image_width_ff & ~CSR_DATA_W'(1)};
      height_ext = {1'b0, image_height_ff};
      if (width_even < EXT_W'(2)) begin
         eff_width = LIM_W'(2);
      end else if (width_even > EXT_W'(MAX_WIDTH)) begin
         eff_width = LIM_W'(MAX_WIDTH - (MAX_WIDTH % 2));
      end else begin
         eff_width = width_even[LIM_W-1:0];
      end
      if (height_ext == '0) begin
         eff_height = LIM_W'(1);
      end else if (height_ext > EXT_W'(MAX_WIDTH)) begin
         eff_height = LIM_W'(MAX_WIDTH);
      end else begin
         eff_height = height_ext[LIM_W-1:0];
      end
   end

   // ------------------------------------------------------------------
   // Pipeline flow control
   // ------------------------------------------------------------------
   logic s1_valid_ff;
   logic s2_valid_ff;
   logic rsp_valid_ff;
   logic adv3;
   logic adv2;
   logic adv1;
   logic accept;
   logic s1_move;
   logic s2_move;

   assign adv3    = !rsp_valid_ff || !rsp_stall;
   assign adv2    = !s2_valid_ff || adv3;
   assign adv1    = !s1_valid_ff || adv2;
   assign accept  = req_valid && adv1;
   assign s1_move = s1_valid_ff && adv2;
   assign s2_move = s2_valid_ff && adv3;

   assign req_stall = !adv1;

   // ------------------------------------------------------------------
   // Stage 0: position counters, line memory access
   // ------------------------------------------------------------------
   logic [CNT_W-1:0] column_count_ff;
   logic [CNT_W-1:0] row_count_ff;
   logic [LIM_W-1:0] col_next;
   logic [LIM_W-1:0] row_next;
   logic             eor;
   logic             eof;
   logic             even_col;
   logic             even_row;
   logic [ADDR_W-1:0] line_addr;

   assign col_next  = {1'b0, column_count_ff} + LIM_W'(1);
   assign row_next  = {1'b0, row_count_ff} + LIM_W'(1);
   assign eor       = col_next >= eff_width;
   assign eof       = eor && (row_next >= eff_height);
   assign even_col  = !column_count_ff[0];
   assign even_row  = !row_count_ff[0];
   assign line_addr = ADDR_W'(column_count_ff >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
      end else if (accept) begin
         if (eor) begin
            column_count_ff <= '0;
            row_count_ff    <= eof ? '0 : row_next[CNT_W-1:0];
         end else begin
            column_count_ff <= col_next[CNT_W-1:0];
         end
      end
   end

   // Chroma line memory: {V, U} per column pair
   logic [15:0] chroma_line [LINE_DEPTH];
   logic [15:0] line_rdata_ff;

   always_ff @(posedge clock) begin
      if (accept && even_col && even_row) begin
         chroma_line[line_addr] <= {req_word.chroma_v, req_word.chroma_u};
      end
   end

   always_ff @(posedge clock) begin
      if (accept && even_col && !even_row) begin
         line_rdata_ff <= chroma_line[line_addr];
      end
   end

   // Stage 1 word
   logic [7:0] s1_luma_ff;
   logic [7:0] s1_v_ff;
   logic [7:0] s1_u_ff;
   logic       s1_even_col_ff;
   logic       s1_even_row_ff;
   logic       s1_eor_ff;
   logic       s1_eof_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv1) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_luma_ff     <= req_word.luma;
         s1_v_ff        <= req_word.chroma_v;
         s1_u_ff        <= req_word.chroma_u;
         s1_even_col_ff <= even_col;
         s1_even_row_ff <= even_row;
         s1_eor_ff      <= eor;
         s1_eof_ff      <= eof;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: chroma select, offsets, constant products
   // ------------------------------------------------------------------
   logic [7:0] held_v_ff;
   logic [7:0] held_u_ff;
   logic [7:0] held_v_in;
   logic [7:0] held_u_in;
   logic [7:0] y_val;
   logic signed [8:0] v_val;
   logic signed [8:0] u_val;

   always_comb begin
      if (s1_even_col_ff && s1_even_row_ff) begin
         held_v_in = s1_v_ff;
         held_u_in = s1_u_ff;
      end else if (s1_even_col_ff) begin
         held_v_in = line_rdata_ff[15:8];
         held_u_in = line_rdata_ff[7:0];
      end else begin
         held_v_in = held_v_ff;
         held_u_in = held_u_ff;
      end
      y_val = (s1_luma_ff < LUMA_OFFSET) ? 8'd0 : s1_luma_ff - LUMA_OFFSET;
      v_val = $signed({1'b0, held_v_in} - CHROMA_OFFSET);
      u_val = $signed({1'b0, held_u_in} - CHROMA_OFFSET);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_v_ff <= '0;
         held_u_ff <= '0;
      end else if (s1_move) begin
         held_v_ff <= held_v_in;
         held_u_ff <= held_u_in;
      end
   end

   logic signed [PROD_W-1:0] p_y_ff;
   logic signed [PROD_W-1:0] p_rv_ff;
   logic signed [PROD_W-1:0] p_gv_ff;
   logic signed [PROD_W-1:0] p_gu_ff;
   logic signed [PROD_W-1:0] p_bu_ff;
   logic                     s2_eor_ff;
   logic                     s2_eof_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         p_y_ff    <= PROD_W'(COEF_Y * int'(y_val));
         p_rv_ff   <= PROD_W'(COEF_RV * int'(v_val));
         p_gv_ff   <= PROD_W'(COEF_GV * int'(v_val));
         p_gu_ff   <= PROD_W'(COEF_GU * int'(u_val));
         p_bu_ff   <= PROD_W'(COEF_BU * int'(u_val));
         s2_eor_ff <= s1_eor_ff;
         s2_eof_ff <= s1_eof_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: sums, saturation, output register
   // ------------------------------------------------------------------
   logic signed [SUM_W-1:0] r_sum;
   logic signed [SUM_W-1:0] g_sum;
   logic signed [SUM_W-1:0] b_sum;
   rsp_word_type            rsp_word_in;
   rsp_word_type            rsp_word_ff;

   always_comb begin
      r_sum = SUM_W'(p_y_ff) + SUM_W'(p_rv_ff);
      g_sum = SUM_W'(p_y_ff) - SUM_W'(p_gv_ff) - SUM_W'(p_gu_ff);
      b_sum = SUM_W'(p_y_ff) + SUM_W'(p_bu_ff);
      rsp_word_in.red          = sat_shift(r_sum);
      rsp_word_in.green        = sat_shift(g_sum);
      rsp_word_in.blue         = sat_shift(b_sum);
      rsp_word_in.end_of_row   = s2_eor_ff;
      rsp_word_in.end_of_frame = s2_eof_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv3) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_move) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef SYNTHESIS
   // Input is held off only when every stage holds a word
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s2_valid_ff && rsp_valid_ff))
      else $error("req_stall with a free pipeline stage");

   // An accepted word always lands in stage 1
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted word lost before stage 1");

   // End of frame is always also end of row
   a_eof_eor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_word_ff.end_of_frame || rsp_word_ff.end_of_row))
      else $error("end_of_frame without end_of_row");

   // A word leaving stage 2 reaches the output register
   a_s2_lands: assert property (@(posedge clock) disable iff (reset)
      s2_move |=> rsp_valid_ff)
      else $error("stage 2 word lost before output");
`endif

endmodule

[verif/tb_nv21_to_xrgb_converter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nv21_to_xrgb_converter_core
// Streams NV21 pixels through the converter under random idle and stall on
// both channels. It predicts each RGB word from its own model of the counters,
// the held chroma pair and the chroma row store, and checks every response in
// order. Geometry is changed between phases, only when the block is drained.
// ----------------------------------------------------------------------------
module tb_nv21_to_xrgb_converter_core;
   import nv21x_pkg::*;

   localparam int MAX_W          = 4096;
   localparam int CHROMA_DEPTH   = MAX_W / 2;
   localparam int Q10_MAX        = 262143;
   localparam int K_Y            = 1192;
   localparam int K_RV           = 1634;
   localparam int K_GV           = 833;
   localparam int K_GU           = 400;
   localparam int K_BU           = 2066;
   localparam int PIXEL_TARGET   = 1250;
   localparam int LONG_HOLD      = 80;
   localparam int WATCHDOG_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   nv21_to_xrgb_converter_core #(.MAX_WIDTH(MAX_W)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial forever #5 clock = ~clock;

   // Pixels waiting to be driven, RGB words waiting to come back
   req_word_type pixel_pending[$];
   rsp_word_type rgb_expected[$];

   int fail_count = 0;
   int words_checked = 0;
   int pixels_sent = 0;
   int idle_cycles = 0;
   logic req_taken = 1'b0;
   int tx_gap = 0;
   int rx_hold = 0;
   int calm_left = 0;
   logic long_hold_done = 1'b0;

   // Converter model state
   logic [CSR_DATA_W-1:0] cfg_width = IMAGE_WIDTH_RST;
   logic [CSR_DATA_W-1:0] cfg_height = IMAGE_HEIGHT_RST;
   logic [11:0] pix_col = '0;
   logic [11:0] pix_row = '0;
   logic [7:0] pair_v = '0;
   logic [7:0] pair_u = '0;
   logic [15:0] chroma_pairs [0:CHROMA_DEPTH-1];

   // Clamp a Q10 sum and keep the integer byte
   function automatic logic [7:0] q10_to_byte(input int s);
      int c;
      c = s;
      if (c < 0) c = 0;
      if (c > Q10_MAX) c = Q10_MAX;
      return 8'(c >> 10);
   endfunction

   // Convert one pixel and advance the raster position
   function automatic rsp_word_type convert_pixel(input req_word_type px);
      int w, h, slot, y, v, u, base;
      logic last_col, last_row;
      rsp_word_type rgb;
      w = int'(cfg_width) & 'h1FFE;
      if (w < 2) w = 2;
      if (w > MAX_W) w = MAX_W;
      h = int'(cfg_height);
      if (h < 1) h = 1;
      if (h > MAX_W) h = MAX_W;
      slot = int'(pix_col >> 1) % CHROMA_DEPTH;
      // even column: even rows latch and store the pair, odd rows fetch it
      if (!pix_col[0]) begin
         if (!pix_row[0]) begin
            pair_v = px.chroma_v;
            pair_u = px.chroma_u;
            chroma_pairs[slot] = {pair_v, pair_u};
         end else begin
            {pair_v, pair_u} = chroma_pairs[slot];
         end
      end
      y = int'(px.luma) - 16;
      if (y < 0) y = 0;
      v = int'(pair_v) - 128;
      u = int'(pair_u) - 128;
      base = K_Y * y;
      rgb.red   = q10_to_byte(base + K_RV * v);
      rgb.green = q10_to_byte(base - K_GV * v - K_GU * u);
      rgb.blue  = q10_to_byte(base + K_BU * u);
      last_col = (int'(pix_col) + 1 >= w);
      last_row = last_col && (int'(pix_row) + 1 >= h);
      rgb.end_of_row = last_col;
      rgb.end_of_frame = last_row;
      if (last_col) begin
         pix_col = '0;
         pix_row = last_row ? 12'd0 : pix_row + 12'd1;
      end else begin
         pix_col = pix_col + 12'd1;
      end
      return rgb;
   endfunction

   function automatic void push_pixel(input logic [7:0] luma, input logic [7:0] v,
                                      input logic [7:0] u);
      req_word_type px;
      px.luma = luma;
      px.chroma_v = v;
      px.chroma_u = u;
      pixel_pending.push_back(px);
      rgb_expected.push_back(convert_pixel(px));
      pixels_sent++;
   endfunction

   // Bytes biased toward the ends and the luma offset
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'($urandom_range(0, 20));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Mostly no gap, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // Wait until every word has come back
   task automatic drain_pipeline();
      while (pixel_pending.size() != 0 || rgb_expected.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx, input int value);
      drain_pipeline();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      if (idx == REG_IMAGE_WIDTH) cfg_width = CSR_DATA_W'(value);
      else cfg_height = CSR_DATA_W'(value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Sender: one word in flight, random gaps, calm stretches without gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         tx_gap <= 0;
         calm_left <= 0;
      end else begin
         if (calm_left > 0) calm_left <= calm_left - 1;
         else if ($urandom_range(0, 199) == 0) calm_left <= $urandom_range(100, 300);
         if (!req_valid || req_taken) begin
            if (tx_gap > 0) begin
               req_valid <= 1'b0;
               tx_gap <= tx_gap - 1;
            end else if (pixel_pending.size() != 0) begin
               req_word <= pixel_pending.pop_front();
               req_valid <= 1'b1;
               tx_gap <= (calm_left > 0) ? 0 : pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall; one long hold while pixels are still queued
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rx_hold <= 0;
         long_hold_done <= 1'b0;
      end else if (rx_hold > 0) begin
         rsp_stall <= 1'b1;
         rx_hold <= rx_hold - 1;
      end else begin
         rsp_stall <= 1'b0;
         if (!long_hold_done && pixel_pending.size() > 16 && words_checked > 40) begin
            rx_hold <= LONG_HOLD;
            long_hold_done <= 1'b1;
         end else if (calm_left == 0) begin
            rx_hold <= pick_gap();
         end
      end
   end

   // Monitor, response check and watchdog
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         req_taken <= 1'b0;
         idle_cycles <= 0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            words_checked++;
            if (rgb_expected.size() == 0) begin
               $error("unexpected word: %h", rsp_word);
               fail_count++;
            end else begin
               want = rgb_expected.pop_front();
               check_field("red", want.red, rsp_word.red);
               check_field("green", want.green, rsp_word.green);
               check_field("blue", want.blue, rsp_word.blue);
               check_field("end_of_row", 8'(want.end_of_row), 8'(rsp_word.end_of_row));
               check_field("end_of_frame", 8'(want.end_of_frame), 8'(rsp_word.end_of_frame));
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // Stimulus
   initial begin
      int mode;
      int burst;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // reset geometry, luma and chroma extremes; odd columns carry junk chroma
      push_pixel(8'd0, 8'd0, 8'd0);
      push_pixel(8'd255, 8'd255, 8'd255);
      push_pixel(8'd16, 8'd255, 8'd255);
      push_pixel(8'd17, 8'd0, 8'd0);
      push_pixel(8'd15, 8'd128, 8'd128);
      push_pixel(8'd235, 8'd0, 8'd255);

      // width below two, height zero; column is past the new width
      write_register(REG_IMAGE_WIDTH, 1);
      write_register(REG_IMAGE_HEIGHT, 0);
      push_pixel(8'd255, 8'd255, 8'd0);
      push_pixel(8'd255, 8'd7, 8'd7);
      push_pixel(8'd0, 8'd0, 8'd255);
      push_pixel(8'd128, 8'd77, 8'd200);

      // small frame, entered mid-row; the odd row reuses the stored pairs
      write_register(REG_IMAGE_WIDTH, 4);
      write_register(REG_IMAGE_HEIGHT, 3);
      repeat (12) push_pixel(pick_byte(), pick_byte(), pick_byte());

      // width and height beyond the maximum
      write_register(REG_IMAGE_WIDTH, 8191);
      write_register(REG_IMAGE_HEIGHT, 8191);
      repeat (3) push_pixel(pick_byte(), pick_byte(), pick_byte());

      // random phases; each ends on an even row so odd rows only read stored pairs
      while (pixels_sent < PIXEL_TARGET) begin
         mode = $urandom_range(0, 19);
         if (mode == 0) begin
            write_register(REG_IMAGE_WIDTH, $urandom_range(4095, 8191));
            if ($urandom_range(0, 1) != 0)
               write_register(REG_IMAGE_HEIGHT, $urandom_range(0, 8191));
            burst = $urandom_range(1, 24);
         end else begin
            if ($urandom_range(0, 2) != 0)
               write_register(REG_IMAGE_WIDTH,
                              (mode == 1) ? $urandom_range(0, 3) : $urandom_range(2, 48));
            if ($urandom_range(0, 2) != 0)
               write_register(REG_IMAGE_HEIGHT,
                              (mode == 1) ? $urandom_range(0, 3) : $urandom_range(1, 8));
            burst = $urandom_range(8, 120);
         end
         repeat (burst) push_pixel(pick_byte(), pick_byte(), pick_byte());
         while (pix_row[0]) push_pixel(pick_byte(), pick_byte(), pick_byte());
      end

      drain_pipeline();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && rgb_expected.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
